### rtl/core/fbpd_pkg.sv
// Shared types and constants for the page framebuffer with dirty rectangle.
package fbpd_pkg;

  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 64;
  localparam int STORE_DEPTH_DEF  = PANEL_WIDTH_DEF * ((PANEL_HEIGHT_DEF + 7) / 8);

  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_TAKE  = 2'd3;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [7:0] PIXEL_BIT0 = 8'h01;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] pix_x;
    logic [7:0] pix_y;
    logic [9:0] byte_addr;
  } fbpd_cmd_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       in_range;
    logic [6:0] dirty_row_start;
    logic [6:0] dirty_row_end;
    logic [7:0] dirty_col_start;
    logic [7:0] dirty_col_end;
  } fbpd_rsp_t;

endpackage

### rtl/core/fbpd_store.sv
// Byte store with registered read and bypass of the most recent write.
module fbpd_store #(
  parameter int DEPTH = fbpd_pkg::STORE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  output logic [7:0]               rd_data
);
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_q;
  logic [ADDR_W-1:0] rd_addr_q;
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  logic [7:0]        fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Latest write always matches the array, so bypassing it is safe at any time;
  // it covers a read issued on the same edge as the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
  end

  assign rd_data = (fwd_valid && (fwd_addr == rd_addr_q)) ? fwd_data : rd_q;

endmodule

### rtl/core/framebuffer_pixel_plot_dirty_rect.sv
// A command passes through the stage 1 registers and then the response register;
// it waits in stage 1 while a response not yet taken holds the response register.
// Throughput: one command per cycle while responses are taken; the store
// read-modify-write is bypassed so back-to-back plots to the same byte stay correct.
// Reset: the store is swept to zero, one byte per cycle over PANEL_WIDTH*pages
// bytes (1024 by default), with cmd_ready low; config writes are taken.
// The dirty rectangle resets empty and the area registers to the panel size.
module framebuffer_pixel_plot_dirty_rect #(
  parameter int PANEL_WIDTH  = fbpd_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = fbpd_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  fbpd_pkg::fbpd_cmd_t cmd_data,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output fbpd_pkg::fbpd_rsp_t rsp_data,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [7:0]          cfg_data
);
  import fbpd_pkg::*;

  localparam int PAGES  = (PANEL_HEIGHT + 7) / 8;
  localparam int DEPTH  = PANEL_WIDTH * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CALC_W = (ADDR_W > 10 ? ADDR_W : 10) + 1;
  localparam int ROW_W  = $clog2(PANEL_HEIGHT + 1);
  localparam int COL_W  = $clog2(PANEL_WIDTH + 1);

  // area registers
  logic [6:0] rows_in_use;
  logic [7:0] cols_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 7'(PANEL_HEIGHT);
      cols_in_use <= 8'(PANEL_WIDTH);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROWS: rows_in_use <= cfg_data[6:0];
        REG_COLS: cols_in_use <= cfg_data;
        default:  ;
      endcase
    end
  end

  // clearing sweep
  logic              clr_active;
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // stage 0: decode and issue the store read
  logic              s1_valid;
  logic              s1_go;
  logic              accept;
  logic              pt_ok;
  logic [CALC_W-1:0] pix_idx;
  logic [CALC_W-1:0] byte_ext;
  logic              addr_oob;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        bit_mask;

  assign s1_go     = s1_valid && (!rsp_valid || rsp_ready);
  assign cmd_ready = !clr_active && (!s1_valid || s1_go);
  assign accept    = cmd_valid && cmd_ready;

  assign pt_ok = (cmd_data.cmd == CMD_SET || cmd_data.cmd == CMD_CLEAR)
              && ({1'b0, cmd_data.pix_y} < {2'b00, rows_in_use})
              && (9'(cmd_data.pix_y) < 9'(PANEL_HEIGHT))
              && (cmd_data.pix_x < cols_in_use)
              && (9'(cmd_data.pix_x) < 9'(PANEL_WIDTH));

  assign pix_idx  = CALC_W'(cmd_data.pix_x)
                  + CALC_W'(cmd_data.pix_y[7:3]) * CALC_W'(PANEL_WIDTH);
  assign byte_ext = CALC_W'(cmd_data.byte_addr);
  assign addr_oob = byte_ext >= CALC_W'(DEPTH);
  assign rd_addr  = (cmd_data.cmd == CMD_READ) ? byte_ext[ADDR_W-1:0]
                                               : pix_idx[ADDR_W-1:0];
  assign bit_mask = PIXEL_BIT0 << cmd_data.pix_y[2:0];

  // stage 1 registers
  logic [1:0]        s1_cmd;
  logic              s1_ok;
  logic              s1_oob;
  logic [7:0]        s1_x;
  logic [7:0]        s1_y;
  logic [7:0]        s1_mask;
  logic [ADDR_W-1:0] s1_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd  <= cmd_data.cmd;
      s1_ok   <= pt_ok;
      s1_oob  <= addr_oob;
      s1_x    <= cmd_data.pix_x;
      s1_y    <= cmd_data.pix_y;
      s1_mask <= bit_mask;
      s1_addr <= rd_addr;
    end
  end

  // store access
  logic [7:0]        st_rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [7:0]        new_byte;

  assign new_byte = (s1_cmd == CMD_SET) ? (st_rd_data | s1_mask)
                                        : (st_rd_data & ~s1_mask);
  assign wr_en    = clr_active || (s1_go && s1_ok);
  assign wr_addr  = clr_active ? clr_addr : s1_addr;
  assign wr_data  = clr_active ? 8'h00 : new_byte;

  fbpd_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_addr(rd_addr),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_data(st_rd_data)
  );

  // dirty rectangle
  logic [ROW_W-1:0] row_lo, row_hi, row_lo_next, row_hi_next;
  logic [COL_W-1:0] col_lo, col_hi, col_lo_next, col_hi_next;
  logic [ROW_W-1:0] y_n;
  logic [COL_W-1:0] x_n;

  assign y_n = ROW_W'(s1_y);
  assign x_n = COL_W'(s1_x);

  always_comb begin
    row_lo_next = row_lo;
    row_hi_next = row_hi;
    col_lo_next = col_lo;
    col_hi_next = col_hi;
    if (s1_cmd == CMD_TAKE) begin
      row_lo_next = ROW_W'(PANEL_HEIGHT);
      row_hi_next = '0;
      col_lo_next = COL_W'(PANEL_WIDTH);
      col_hi_next = '0;
    end else if (s1_ok) begin
      if (row_lo > y_n)  row_lo_next = y_n;
      if (row_hi <= y_n) row_hi_next = y_n + ROW_W'(1);
      if (col_lo > x_n)  col_lo_next = x_n;
      if (col_hi <= x_n) col_hi_next = x_n + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_lo <= ROW_W'(PANEL_HEIGHT);
      row_hi <= '0;
      col_lo <= COL_W'(PANEL_WIDTH);
      col_hi <= '0;
    end else if (s1_go) begin
      row_lo <= row_lo_next;
      row_hi <= row_hi_next;
      col_lo <= col_lo_next;
      col_hi <= col_hi_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      rsp_data.read_byte <= (s1_cmd == CMD_READ && !s1_oob) ? st_rd_data : 8'h00;
      rsp_data.in_range  <= s1_ok;
      // take reports the rectangle as it was before emptying
      if (s1_cmd == CMD_TAKE) begin
        rsp_data.dirty_row_start <= 7'(row_lo);
        rsp_data.dirty_row_end   <= 7'(row_hi);
        rsp_data.dirty_col_start <= 8'(col_lo);
        rsp_data.dirty_col_end   <= 8'(col_hi);
      end else begin
        rsp_data.dirty_row_start <= 7'(row_lo_next);
        rsp_data.dirty_row_end   <= 7'(row_hi_next);
        rsp_data.dirty_col_start <= 8'(col_lo_next);
        rsp_data.dirty_col_end   <= 8'(col_hi_next);
      end
    end
  end

  // checks
  a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !cmd_ready)
    else $error("command taken during store clear");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (clr_active || (s1_valid && s1_ok &&
               (s1_cmd == CMD_SET || s1_cmd == CMD_CLEAR))))
    else $error("store write without an in-range plot");

  a_take_empties: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_cmd == CMD_TAKE) |=>
      (row_lo == ROW_W'(PANEL_HEIGHT) && row_hi == '0 &&
       col_lo == COL_W'(PANEL_WIDTH) && col_hi == '0))
    else $error("dirty rectangle not emptied by take");

  a_rect_ordered: assert property (@(posedge clk) disable iff (rst)
    (row_lo != ROW_W'(PANEL_HEIGHT)) |-> (row_hi > row_lo && col_hi > col_lo))
    else $error("dirty rectangle bounds inverted");

endmodule
